FILE: rtl/qtci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtci_pkg
// Shared constants, codes, the grid probability table and the control and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package qtci_pkg;

  localparam int TABLE_DEPTH = 103;
  localparam int LAST_IDX    = TABLE_DEPTH - 1;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int DATA_W      = 32;
  localparam int PROB_W      = 30;
  localparam int OPR_W       = DATA_W + 1;
  localparam int MUL_LO_W    = 17;
  localparam int MUL_HI_W    = OPR_W - MUL_LO_W;
  localparam int PP_W        = OPR_W + MUL_LO_W;
  localparam int PROD_W      = 2 * OPR_W;
  localparam int RES_W       = PROD_W + 2;
  localparam int DIV_STEPS   = PROD_W;
  localparam int CNT_W       = $clog2(DIV_STEPS);
  localparam longint PROB_ONE = 64'd1073741824;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_CDF   = 2'd1,
    ACT_QUANT = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LOAD  = 2'd1,
    ST_SAT   = 2'd2,
    ST_DEGEN = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    EMIT_LOAD,
    EMIT_SAT_LO,
    EMIT_SAT_HI,
    EMIT_DEGEN,
    EMIT_ARITH
  } emit_t;

  typedef logic [PROB_W-1:0] prob_tbl_t [TABLE_DEPTH];

  // Grid probabilities in Q0.30, rounded to nearest
  function automatic prob_tbl_t build_prob();
    prob_tbl_t tbl;
    longint    v;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == 0) v = 64'd107374;
      else if (i == 1) v = 64'd1073742;
      else if (i == LAST_IDX - 1) v = 64'd1072668082;
      else if (i == LAST_IDX) v = 64'd1073634450;
      else v = ((longint'(i) - 1) * PROB_ONE + 50) / 100;
      tbl[i] = PROB_W'(v);
    end
    return tbl;
  endfunction

  localparam prob_tbl_t PROB_TBL = build_prob();

  typedef struct packed {
    logic             capture;
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             lo_load;
    logic             setup;
    logic             mul_lo;
    logic             mul_hi;
    logic             div_step;
    logic             finish;
    logic             emit;
    emit_t            emit_kind;
    logic [IDX_W-1:0] k;
    logic             anc_hi;
    logic             cdf_mode;
    logic [IDX_W-1:0] scan_idx;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    x_le_lo;
    logic    x_ge_rd;
    logic    x_le_rd;
    logic    p_nonpos;
    logic    p_ge_one;
    logic    p_le_first;
    logic    p_ge_last;
    logic    p_ge_next;
    logic    d_zero;
    logic    d_nonpos;
    logic    out_free;
  } sts_t;

endpackage

FILE: rtl/qtci_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtci_in_if
// Input channel: valid/ready handshake with one load or query per beat.
// ----------------------------------------------------------------------------
interface qtci_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [6:0]  entry_index;
  logic signed [31:0] operand_value;

  modport source (output valid, action, entry_index, operand_value, input ready);
  modport sink   (input valid, action, entry_index, operand_value, output ready);
endinterface

FILE: rtl/qtci_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtci_out_if
// Output channel: valid/ready handshake with one result per beat.
// ----------------------------------------------------------------------------
interface qtci_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic [1:0]  status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

FILE: rtl/qtci_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtci_ctrl
// Sequencer: decodes an item, walks the table or the grid to find the
// bracketing segment, then runs multiply, divide and result steps.
// ----------------------------------------------------------------------------
module qtci_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  qtci_pkg::sts_t  sts,
  output qtci_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CDF_LO,
    S_CDF_HI,
    S_CDF_SCAN,
    S_Q_SCAN,
    S_PAIR_LO,
    S_PAIR_HI,
    S_SETUP,
    S_CHECK,
    S_MUL,
    S_DIV,
    S_FINISH,
    S_EMIT
  } state_t;

  localparam logic [qtci_pkg::IDX_W-1:0] IDX_LAST = qtci_pkg::IDX_W'(qtci_pkg::LAST_IDX);
  localparam logic [qtci_pkg::IDX_W-1:0] IDX_PREV = qtci_pkg::IDX_W'(qtci_pkg::LAST_IDX - 1);
  localparam logic [qtci_pkg::CNT_W-1:0] CNT_LAST = qtci_pkg::CNT_W'(qtci_pkg::DIV_STEPS - 1);

  state_t                        state, state_next;
  logic [qtci_pkg::IDX_W-1:0]    idx, idx_next;
  logic [qtci_pkg::IDX_W-1:0]    k, k_next;
  logic                          anc_hi, anc_hi_next;
  logic                          le_mode, le_mode_next;
  logic                          cdf_mode, cdf_mode_next;
  logic [qtci_pkg::CNT_W-1:0]    cnt, cnt_next;
  qtci_pkg::emit_t               kind, kind_next;

  // Next state and commands
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    k_next        = k;
    anc_hi_next   = anc_hi;
    le_mode_next  = le_mode;
    cdf_mode_next = cdf_mode;
    cnt_next      = cnt;
    kind_next     = kind;
    cmd           = '0;
    cmd.emit_kind = kind;
    cmd.k         = k;
    cmd.anc_hi    = anc_hi;
    cmd.cdf_mode  = cdf_mode;
    cmd.scan_idx  = idx;
    in_ready      = (state == S_IDLE);

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.action)
          qtci_pkg::ACT_LOAD: begin
            cmd.wr_en  = 1'b1;
            kind_next  = qtci_pkg::EMIT_LOAD;
            state_next = S_EMIT;
          end
          qtci_pkg::ACT_CDF: begin
            cdf_mode_next = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_addr   = '0;
            state_next    = S_CDF_LO;
          end
          qtci_pkg::ACT_QUANT: begin
            cdf_mode_next = 1'b0;
            priority if (sts.p_nonpos) begin
              kind_next  = qtci_pkg::EMIT_SAT_LO;
              state_next = S_EMIT;
            end else if (sts.p_ge_one) begin
              kind_next  = qtci_pkg::EMIT_SAT_HI;
              state_next = S_EMIT;
            end else if (sts.p_le_first) begin
              k_next      = '0;
              anc_hi_next = 1'b0;
              state_next  = S_PAIR_LO;
            end else if (sts.p_ge_last) begin
              k_next      = IDX_PREV;
              anc_hi_next = 1'b1;
              state_next  = S_PAIR_LO;
            end else begin
              idx_next   = '0;
              state_next = S_Q_SCAN;
            end
          end
          qtci_pkg::ACT_NONE: begin
            state_next = S_IDLE;
          end
        endcase
      end
      // Hold entry 0, fetch the last entry
      S_CDF_LO: begin
        cmd.lo_load = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = IDX_LAST;
        state_next  = S_CDF_HI;
      end
      // Pick a tail segment or start the walk
      S_CDF_HI: begin
        priority if (sts.x_le_lo) begin
          k_next       = '0;
          anc_hi_next  = 1'b0;
          le_mode_next = 1'b0;
          state_next   = S_PAIR_LO;
        end else if (sts.x_ge_rd) begin
          k_next       = IDX_PREV;
          anc_hi_next  = 1'b1;
          le_mode_next = 1'b0;
          state_next   = S_PAIR_LO;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = qtci_pkg::IDX_W'(1);
          idx_next    = qtci_pkg::IDX_W'(1);
          state_next  = S_CDF_SCAN;
        end
      end
      // Walk the table, one entry a cycle
      S_CDF_SCAN: begin
        if (sts.x_le_rd || idx == IDX_LAST) begin
          k_next       = idx - qtci_pkg::IDX_W'(1);
          anc_hi_next  = 1'b1;
          le_mode_next = 1'b1;
          state_next   = S_PAIR_LO;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = idx + qtci_pkg::IDX_W'(1);
          idx_next    = idx + qtci_pkg::IDX_W'(1);
        end
      end
      // Walk the grid probabilities, one a cycle
      S_Q_SCAN: begin
        if (idx < IDX_PREV && sts.p_ge_next) begin
          idx_next = idx + qtci_pkg::IDX_W'(1);
        end else begin
          k_next      = idx;
          anc_hi_next = 1'b0;
          state_next  = S_PAIR_LO;
        end
      end
      S_PAIR_LO: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = k;
        state_next  = S_PAIR_HI;
      end
      S_PAIR_HI: begin
        cmd.lo_load = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = k + qtci_pkg::IDX_W'(1);
        state_next  = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_CHECK;
      end
      // In CDF mode flag a zero-width segment (after the walk, a nonpositive one), otherwise start the multiply
      S_CHECK: begin
        if (cdf_mode && (le_mode ? sts.d_nonpos : sts.d_zero)) begin
          kind_next  = qtci_pkg::EMIT_DEGEN;
          state_next = S_EMIT;
        end else begin
          cmd.mul_lo = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_hi = 1'b1;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_LAST) begin
          state_next = S_FINISH;
        end else begin
          cnt_next = cnt + qtci_pkg::CNT_W'(1);
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        kind_next  = qtci_pkg::EMIT_ARITH;
        state_next = S_EMIT;
      end
      // Hand the result to the output register once it is free
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      idx      <= '0;
      k        <= '0;
      anc_hi   <= 1'b0;
      le_mode  <= 1'b0;
      cdf_mode <= 1'b0;
      cnt      <= '0;
      kind     <= qtci_pkg::EMIT_LOAD;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      k        <= k_next;
      anc_hi   <= anc_hi_next;
      le_mode  <= le_mode_next;
      cdf_mode <= cdf_mode_next;
      cnt      <= cnt_next;
      kind     <= kind_next;
    end
  end

endmodule

FILE: rtl/qtci_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtci_dp
// Datapath: quantile table memory, segment operand setup, shared 33x17
// multiplier, restoring divider, clamp and output register.
// ----------------------------------------------------------------------------
module qtci_dp (
  input  logic               clk,
  input  logic               rst,
  input  qtci_pkg::cmd_t     cmd,
  output qtci_pkg::sts_t     sts,
  input  logic [1:0]         action,
  input  logic [6:0]         entry_index,
  input  logic signed [31:0] operand_value,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] result_value,
  output logic [1:0]         status
);

  localparam int IW = qtci_pkg::IDX_W;
  localparam int OW = qtci_pkg::OPR_W;
  localparam int PW = qtci_pkg::PROD_W;
  localparam int RW = qtci_pkg::RES_W;
  localparam logic signed [RW-1:0] R_ONE  = RW'(qtci_pkg::PROB_ONE);
  localparam logic signed [RW-1:0] R_MIN  = -(RW'(64'd2147483648));
  localparam logic signed [RW-1:0] R_MAX  = RW'(64'd2147483647);
  localparam logic signed [31:0]   P_ONE  = 32'(qtci_pkg::PROB_ONE);

  qtci_pkg::action_t        act_q;
  logic [IW-1:0]            idx_q;
  logic signed [31:0]       opnd_q;
  logic [31:0]              mem [qtci_pkg::TABLE_DEPTH];
  logic signed [31:0]       rdata;
  logic signed [31:0]       lo;
  logic [OW-1:0]            a_mag, b_mag, d_mag;
  logic                     neg;
  logic signed [OW-1:0]     base;
  logic                     d_zero, d_nonpos;
  logic [PW-1:0]            prod;
  logic [OW-1:0]            rem;
  logic signed [RW-1:0]     r;

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q  <= qtci_pkg::action_t'(action);
      idx_q  <= entry_index;
      opnd_q <= operand_value;
    end
  end

  // Table memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en && idx_q < IW'(qtci_pkg::TABLE_DEPTH)) begin
      mem[idx_q] <= opnd_q;
    end
    if (cmd.rd_en) begin
      rdata <= mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lo_load) begin
      lo <= rdata;
    end
  end

  // Compare results for the sequencer
  logic [IW-1:0]        next_idx;
  logic signed [31:0]   p_next;
  assign next_idx = (cmd.scan_idx >= IW'(qtci_pkg::LAST_IDX)) ?
                    IW'(qtci_pkg::LAST_IDX) : cmd.scan_idx + IW'(1);
  assign p_next   = {2'b00, qtci_pkg::PROB_TBL[next_idx]};

  always_comb begin
    sts.action     = act_q;
    sts.x_le_lo    = opnd_q <= lo;
    sts.x_ge_rd    = opnd_q >= rdata;
    sts.x_le_rd    = opnd_q <= rdata;
    sts.p_nonpos   = opnd_q <= 32'sd0;
    sts.p_ge_one   = opnd_q >= P_ONE;
    sts.p_le_first = opnd_q <= $signed({2'b00, qtci_pkg::PROB_TBL[0]});
    sts.p_ge_last  = opnd_q >= $signed({2'b00, qtci_pkg::PROB_TBL[qtci_pkg::LAST_IDX]});
    sts.p_ge_next  = opnd_q >= p_next;
    sts.d_zero     = d_zero;
    sts.d_nonpos   = d_nonpos;
    sts.out_free   = !out_valid || out_ready;
  end

  // Segment operands: result = base + a * b / d
  logic signed [OW-1:0] x_s, lo_s, hi_s, pk_s, pk1_s, dt_s, dp_s;
  logic signed [OW-1:0] anc_p, anc_t, a_s, b_s, d_s;
  logic [IW-1:0]        k1;

  assign k1    = cmd.k + IW'(1);
  assign x_s   = OW'(opnd_q);
  assign lo_s  = OW'(lo);
  assign hi_s  = OW'(rdata);
  assign pk_s  = $signed({3'b000, qtci_pkg::PROB_TBL[cmd.k]});
  assign pk1_s = $signed({3'b000, qtci_pkg::PROB_TBL[k1]});
  assign dt_s  = hi_s - lo_s;
  assign dp_s  = pk1_s - pk_s;
  assign anc_p = cmd.anc_hi ? pk1_s : pk_s;
  assign anc_t = cmd.anc_hi ? hi_s : lo_s;
  assign a_s   = cmd.cdf_mode ? x_s - anc_t : x_s - anc_p;
  assign b_s   = cmd.cdf_mode ? dp_s : dt_s;
  assign d_s   = cmd.cdf_mode ? dt_s : dp_s;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      a_mag    <= a_s[OW-1] ? -a_s : a_s;
      b_mag    <= b_s[OW-1] ? -b_s : b_s;
      d_mag    <= d_s[OW-1] ? -d_s : d_s;
      neg      <= a_s[OW-1] ^ b_s[OW-1] ^ d_s[OW-1];
      base     <= cmd.cdf_mode ? anc_p : anc_t;
      d_zero   <= d_s == '0;
      d_nonpos <= d_s[OW-1] || d_s == '0;
    end
  end

  // Shared multiplier in a low and a high pass, then one quotient bit a cycle
  logic [qtci_pkg::MUL_LO_W-1:0] mul_b;
  logic [qtci_pkg::PP_W-1:0]     pp;
  logic [OW:0]                   trial;

  assign mul_b = cmd.mul_hi ? qtci_pkg::MUL_LO_W'(b_mag[OW-1:qtci_pkg::MUL_LO_W]) :
                              b_mag[qtci_pkg::MUL_LO_W-1:0];
  assign pp    = qtci_pkg::PP_W'(a_mag) * qtci_pkg::PP_W'(mul_b);
  assign trial = {rem, prod[PW-1]};

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      prod <= PW'(pp);
      rem  <= '0;
    end else if (cmd.mul_hi) begin
      prod <= prod + (PW'(pp) << qtci_pkg::MUL_LO_W);
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, d_mag}) begin
        rem  <= OW'(trial - {1'b0, d_mag});
        prod <= {prod[PW-2:0], 1'b1};
      end else begin
        rem  <= trial[OW-1:0];
        prod <= {prod[PW-2:0], 1'b0};
      end
    end
  end

  // Apply the quotient sign and add the anchor
  logic signed [RW-1:0] q_s;
  assign q_s = $signed({2'b00, prod});

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      r <= RW'(base) + (neg ? -q_s : q_s);
    end
  end

  // Clamp or saturate the arithmetic result
  logic signed [31:0]  arith_val;
  qtci_pkg::status_t   arith_st;
  always_comb begin
    arith_val = r[31:0];
    arith_st  = qtci_pkg::ST_OK;
    if (cmd.cdf_mode) begin
      if (r < 0) begin
        arith_val = '0;
        arith_st  = qtci_pkg::ST_SAT;
      end else if (r > R_ONE) begin
        arith_val = P_ONE;
        arith_st  = qtci_pkg::ST_SAT;
      end
    end else begin
      if (r < R_MIN) begin
        arith_val = R_MIN[31:0];
        arith_st  = qtci_pkg::ST_SAT;
      end else if (r > R_MAX) begin
        arith_val = R_MAX[31:0];
        arith_st  = qtci_pkg::ST_SAT;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      unique case (cmd.emit_kind)
        qtci_pkg::EMIT_LOAD: begin
          result_value <= '0;
          status       <= qtci_pkg::ST_LOAD;
        end
        qtci_pkg::EMIT_SAT_LO: begin
          result_value <= R_MIN[31:0];
          status       <= qtci_pkg::ST_SAT;
        end
        qtci_pkg::EMIT_SAT_HI: begin
          result_value <= R_MAX[31:0];
          status       <= qtci_pkg::ST_SAT;
        end
        qtci_pkg::EMIT_DEGEN: begin
          result_value <= base[31:0];
          status       <= qtci_pkg::ST_DEGEN;
        end
        qtci_pkg::EMIT_ARITH: begin
          result_value <= arith_val;
          status       <= arith_st;
        end
        default: begin
          result_value <= '0;
          status       <= qtci_pkg::ST_OK;
        end
      endcase
    end
  end

endmodule

FILE: rtl/quantile_table_cdf_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantile_table_cdf_interpolator
// Piecewise-linear CDF and quantile lookup over a 103-entry quantile table.
//
//   channel  dir  beat contents
//   in_ch    in   action, entry_index, operand_value
//   out_ch   out  result_value, status
//
// One item at a time. A query that falls inside the table or the grid walks
// it to its segment (one entry a cycle, up to 102 entries), then runs a
// bit-serial divide. Reset is synchronous; the table holds no reset value.
// A stalled output holds its result while the next item is already being
// accepted.
// ----------------------------------------------------------------------------
module quantile_table_cdf_interpolator (
  input  logic        clk,
  input  logic        rst,
  qtci_in_if.sink     in_ch,
  qtci_out_if.source  out_ch
);

  qtci_pkg::cmd_t cmd;
  qtci_pkg::sts_t sts;

  qtci_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qtci_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .action        (in_ch.action),
    .entry_index   (in_ch.entry_index),
    .operand_value (in_ch.operand_value),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .result_value  (out_ch.result_value),
    .status        (out_ch.status)
  );

endmodule

FILE: rtl/qtci_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtci_checker
// Port-level checks on the interpolator, attached by bind.
// ----------------------------------------------------------------------------
module qtci_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] result_value,
  input logic [1:0]  status
);

  // Stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(status))
    else $error("stalled result changed");

  // One item in flight: ready drops after an accepted beat
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // Load acknowledge carries zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == qtci_pkg::ST_LOAD |-> result_value == 32'd0)
    else $error("load acknowledge with nonzero value");

  // Saturated results sit at a bound
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == qtci_pkg::ST_SAT |->
      result_value == 32'd0 || result_value == 32'h4000_0000 ||
      result_value == 32'h8000_0000 || result_value == 32'h7fff_ffff)
    else $error("saturated result off a bound");

endmodule

bind quantile_table_cdf_interpolator qtci_checker u_qtci_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .result_value (out_ch.result_value),
  .status       (out_ch.status)
);

FILE: tb/sv/quantile_table_cdf_interpolator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantile_table_cdf_interpolator_tb
// Loads quantile tables of several shapes (ascending, with flat or inverted
// segments, very wide) and runs CDF and quantile queries against them. Each
// result is checked against an in-bench interpolator that tracks its own
// copy of the table. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module quantile_table_cdf_interpolator_tb;

  localparam longint P_ONE = 64'd1073741824;

  // Tracks the table and the queue of expected results
  class interp_scoreboard;
    logic [31:0]        qtab [qtci_pkg::TABLE_DEPTH];
    logic [31:0]        exp_val [$];
    qtci_pkg::status_t  exp_st [$];
    int                 errors = 0;

    function longint grid_prob(int i);
      if (i <= 0) return 64'd107374;
      if (i == 1) return 64'd1073742;
      if (i == 101) return 64'd1072668082;
      if (i >= 102) return 64'd1073634450;
      return (longint'(i - 1) * P_ONE + 50) / 100;
    endfunction

    function longint entry(int i);
      return longint'($signed(qtab[i]));
    endfunction

    function void push(longint v, qtci_pkg::status_t s);
      exp_val.push_back(v[31:0]);
      exp_st.push_back(s);
    endfunction

    function void cdf_at(longint x);
      longint r;
      longint den;
      int     i;
      if (x <= entry(0)) begin
        den = entry(1) - entry(0);
        if (den == 0) begin
          push(grid_prob(0), qtci_pkg::ST_DEGEN);
          return;
        end
        r = grid_prob(0) + (x - entry(0)) * (grid_prob(1) - grid_prob(0)) / den;
      end else if (x >= entry(102)) begin
        den = entry(102) - entry(101);
        if (den == 0) begin
          push(grid_prob(102), qtci_pkg::ST_DEGEN);
          return;
        end
        r = grid_prob(102) + (x - entry(102)) * (grid_prob(102) - grid_prob(101)) / den;
      end else begin
        i = 1;
        while (i < 102 && x > entry(i)) i++;
        den = entry(i) - entry(i - 1);
        if (den <= 0) begin
          push(grid_prob(i), qtci_pkg::ST_DEGEN);
          return;
        end
        r = grid_prob(i) - (entry(i) - x) * (grid_prob(i) - grid_prob(i - 1)) / den;
      end
      if (r < 0) push(0, qtci_pkg::ST_SAT);
      else if (r > P_ONE) push(P_ONE, qtci_pkg::ST_SAT);
      else push(r, qtci_pkg::ST_OK);
    endfunction

    function void quantile_at(longint p);
      longint r;
      int     i;
      if (p <= 0) begin
        push(-64'sd2147483648, qtci_pkg::ST_SAT);
        return;
      end
      if (p >= P_ONE) begin
        push(64'sd2147483647, qtci_pkg::ST_SAT);
        return;
      end
      if (p <= grid_prob(0)) begin
        r = entry(0) + (p - grid_prob(0)) * (entry(1) - entry(0))
            / (grid_prob(1) - grid_prob(0));
      end else if (p >= grid_prob(102)) begin
        r = entry(102) + (p - grid_prob(102)) * (entry(102) - entry(101))
            / (grid_prob(102) - grid_prob(101));
      end else begin
        i = 0;
        while (i < 101 && p >= grid_prob(i + 1)) i++;
        r = entry(i) + (p - grid_prob(i)) * (entry(i + 1) - entry(i))
            / (grid_prob(i + 1) - grid_prob(i));
      end
      if (r < -64'sd2147483648) push(-64'sd2147483648, qtci_pkg::ST_SAT);
      else if (r > 64'sd2147483647) push(64'sd2147483647, qtci_pkg::ST_SAT);
      else push(r, qtci_pkg::ST_OK);
    endfunction

    // Note an accepted input beat
    function void note(qtci_pkg::action_t act, logic [6:0] idx, logic [31:0] opnd);
      case (act)
        qtci_pkg::ACT_LOAD: begin
          if (idx < qtci_pkg::TABLE_DEPTH) qtab[idx] = opnd;
          push(0, qtci_pkg::ST_LOAD);
        end
        qtci_pkg::ACT_CDF:   cdf_at(longint'($signed(opnd)));
        qtci_pkg::ACT_QUANT: quantile_at(longint'($signed(opnd)));
        default: ;
      endcase
    endfunction

    // Check an accepted output beat against the oldest expectation
    function void check(logic [31:0] v, logic [1:0] s);
      if (exp_val.size() == 0) begin
        $display("%0t: unexpected result value %h status %0d", $realtime, v, s);
        errors++;
        return;
      end
      if (v !== exp_val[0] || s !== exp_st[0]) begin
        $display("%0t: mismatch: expected value %h status %0d, got value %h status %0d",
                 $realtime, exp_val[0], exp_st[0], v, s);
        errors++;
      end
      void'(exp_val.pop_front());
      void'(exp_st.pop_front());
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   idle_pct = 0;
  int   stall_pct = 0;
  logic [31:0] shadow [qtci_pkg::TABLE_DEPTH];
  interp_scoreboard sb = new();

  qtci_in_if  in_ch ();
  qtci_out_if out_ch ();

  quantile_table_cdf_interpolator u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #2 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = qtci_pkg::ACT_NONE;
    in_ch.entry_index = '0;
    in_ch.operand_value = '0;
    out_ch.ready = 1'b0;
  end

  // Stall the receiver at random
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Check every output beat
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check(out_ch.result_value, out_ch.status);
  end

  // Drive one beat, with random sender gaps, and note it once accepted
  task automatic send(qtci_pkg::action_t act, logic [6:0] idx, logic [31:0] opnd);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.entry_index <= idx;
    in_ch.operand_value <= opnd;
    do @(posedge clk); while (!in_ch.ready);
    sb.note(act, idx, opnd);
  endtask

  task automatic load(int i, logic [31:0] v);
    shadow[i] = v;
    send(qtci_pkg::ACT_LOAD, 7'(i), v);
  endtask

  // Load a whole table: 0 ascending fine, 1 ascending wide, 2 flat runs, 3 arbitrary
  task automatic load_table(int shape);
    logic [31:0] v;
    v = $urandom();
    if (shape != 3) v = 32'(int'($urandom_range(65535)) - 32768) << $urandom_range(16);
    if (shape == 1) v = 32'h8000_0000 + $urandom_range(1 << 20);
    for (int i = 0; i < qtci_pkg::TABLE_DEPTH; i++) begin
      case (shape)
        0: v = v + $urandom_range(1 << $urandom_range(20));
        1: v = v + $urandom_range(32'h0280_0000);
        2: if ($urandom_range(2) == 0) v = v + $urandom_range(4096);
        default: v = $urandom();
      endcase
      load(i, v);
    end
  endtask

  // One random query shaped around the current table
  task automatic query();
    logic [31:0] x;
    longint      p;
    int          k;
    k = $urandom_range(qtci_pkg::TABLE_DEPTH - 1);
    if ($urandom_range(1)) begin
      case ($urandom_range(3))
        0: x = $urandom();
        1: x = shadow[k];
        default: x = shadow[k] + int'($urandom_range(8192)) - 4096;
      endcase
      send(qtci_pkg::ACT_CDF, 7'($urandom()), x);
    end else begin
      p = sb.grid_prob(k);
      case ($urandom_range(4))
        0: x = $urandom();
        1: x = p[31:0];
        2: x = p[31:0] + int'($urandom_range(4)) - 2;
        3: x = $urandom_range(107374);
        default: x = $urandom_range(P_ONE);
      endcase
      if ($urandom_range(9) == 0) x = P_ONE - $urandom_range(1073634450 / 256);
      send(qtci_pkg::ACT_QUANT, 7'($urandom()), x);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: ascending table, then each special case
    for (int i = 0; i < qtci_pkg::TABLE_DEPTH; i++) load(i, 32'((i - 51) * 65536));
    send(qtci_pkg::ACT_LOAD, 7'd103, 32'h1234_5678);
    send(qtci_pkg::ACT_LOAD, 7'd127, 32'hffff_ffff);
    send(qtci_pkg::ACT_NONE, 7'd5, 32'h0);
    send(qtci_pkg::ACT_CDF, 7'd0, 32'h8000_0000);
    send(qtci_pkg::ACT_CDF, 7'd127, 32'h7fff_ffff);
    send(qtci_pkg::ACT_CDF, 7'd0, shadow[0]);
    send(qtci_pkg::ACT_CDF, 7'd0, shadow[102]);
    send(qtci_pkg::ACT_CDF, 7'd0, 32'h0000_8000);
    send(qtci_pkg::ACT_QUANT, 7'd0, 32'h0);
    send(qtci_pkg::ACT_QUANT, 7'd0, 32'h8000_0000);
    send(qtci_pkg::ACT_QUANT, 7'd0, 32'h4000_0000);
    send(qtci_pkg::ACT_QUANT, 7'd0, 32'h7fff_ffff);
    send(qtci_pkg::ACT_QUANT, 7'd0, 32'd1);
    send(qtci_pkg::ACT_QUANT, 7'd0, 32'd1073742);
    send(qtci_pkg::ACT_QUANT, 7'd0, 32'h3fff_ffff);
    // flat tails and a flat interior segment
    load(1, shadow[0]);
    load(101, shadow[102]);
    load(50, shadow[49]);
    send(qtci_pkg::ACT_CDF, 7'd0, 32'h8000_0000);
    send(qtci_pkg::ACT_CDF, 7'd0, 32'h7fff_ffff);
    send(qtci_pkg::ACT_CDF, 7'd0, shadow[49] + 1);
    // steep upper tail overflows the quantile
    load(101, 32'h0);
    load(102, 32'h7fff_0000);
    send(qtci_pkg::ACT_QUANT, 7'd0, 32'h3fff_ffff);

    // Random phases with different sender idling and receiver stalls
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 62 : (ph == 3) ? 14 : 0;
      stall_pct = (ph == 2) ? 62 : (ph == 3) ? 14 : 0;
      for (int t = 0; t < 2; t++) begin
        load_table($urandom_range(3));
        for (int q = 0; q < 135; q++) begin
          if ($urandom_range(19) == 0) begin
            send(qtci_pkg::ACT_NONE, 7'($urandom()), $urandom());
          end else if ($urandom_range(19) == 0) begin
            send(qtci_pkg::ACT_LOAD, 7'($urandom_range(103, 127)), $urandom());
          end else if ($urandom_range(19) == 0) begin
            load($urandom_range(qtci_pkg::TABLE_DEPTH - 1), $urandom());
          end else begin
            query();
          end
        end
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.exp_val.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("quantile_table_cdf_interpolator regression: pass");
    else $display("quantile_table_cdf_interpolator regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("quantile_table_cdf_interpolator regression: fail");
    $finish;
  end

endmodule
